/* sv/world_aabb_from_points_core_macros.svh */
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef WORLD_AABB_FROM_POINTS_CORE_MACROS_SVH
`define WORLD_AABB_FROM_POINTS_CORE_MACROS_SVH

// Same-cycle implication.
`define WAFP_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WAFP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wafp_pkg.sv */
`timescale 1ns / 1ps
package wafp_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned COEF_W  = 16;
	localparam int unsigned ROW_W   = 48;
	localparam int unsigned PROD_W  = COORD_W + COEF_W;
	localparam int unsigned ACC_W   = PROD_W + 2;
	localparam int unsigned FRAC_DROP = 12;

	localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

	localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] NEG_MAX = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_ROW_X,
		REG_ROW_Y,
		REG_ROW_Z,
		REG_SHIFT_X,
		REG_SHIFT_Y,
		REG_SHIFT_Z
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] corner;
		logic [1:0] row;
		logic [1:0] term;
	} step_t;

	typedef struct packed {
		logic  idle;
		logic  done;
		step_t step;
	} ctl_t;

	typedef struct packed {
		logic                      valid;
		logic                      first;
		logic                      last;
		logic [1:0]                axis;
		logic signed [COEF_W-1:0]  coef;
		logic signed [COORD_W-1:0] coord;
		logic signed [COORD_W-1:0] shift;
	} mac_op_t;

	typedef struct packed {
		logic                      valid;
		logic [1:0]                axis;
		logic signed [COORD_W-1:0] value;
	} mac_res_t;

endpackage

/* sv/wafp_ifs.sv */
`timescale 1ns / 1ps
interface wafp_point_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       point_x;
	logic signed [31:0]       point_y;
	logic signed [31:0]       point_z;
	logic                     final_point;

	modport source (output valid, point_x, point_y, point_z, final_point, input ready);
	modport sink (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface wafp_box_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_min_x;
	logic signed [31:0] world_min_y;
	logic signed [31:0] world_min_z;
	logic signed [31:0] world_max_x;
	logic signed [31:0] world_max_y;
	logic signed [31:0] world_max_z;

	modport source (output valid, world_min_x, world_min_y, world_min_z,
		world_max_x, world_max_y, world_max_z, input ready);
	modport sink (input valid, world_min_x, world_min_y, world_min_z,
		world_max_x, world_max_y, world_max_z, output ready);
endinterface

/* sv/wafp_mac.sv */
`timescale 1ns / 1ps
module wafp_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  wafp_pkg::mac_op_t op,
	output wafp_pkg::mac_res_t res,
	output logic              busy
);

	logic                                    valid_s1, first_s1, last_s1;
	logic [1:0]                              axis_s1;
	logic signed [wafp_pkg::PROD_W-1:0]      prod_s1;
	logic signed [wafp_pkg::COORD_W-1:0]     shift_s1;
	logic signed [wafp_pkg::PROD_W-1:0]      prod_d;

	logic                                    valid_s2;
	logic [1:0]                              axis_s2;
	logic signed [wafp_pkg::ACC_W-1:0]       acc_q;
	logic signed [wafp_pkg::COORD_W-1:0]     shift_s2;
	logic signed [wafp_pkg::ACC_W-1:0]       prod_ext;

	logic                                    valid_s3;
	logic [1:0]                              axis_s3;
	logic signed [wafp_pkg::COORD_W-1:0]     value_s3;

	logic signed [wafp_pkg::ACC_W-1:0]       rnd;
	logic signed [wafp_pkg::ACC_W-wafp_pkg::FRAC_DROP-1:0] flr;
	logic signed [wafp_pkg::ACC_W-wafp_pkg::FRAC_DROP:0]   sum;
	logic signed [wafp_pkg::COORD_W-1:0]     sat;

	assign prod_d   = op.coef * op.coord;
	assign prod_ext = {{2{prod_s1[wafp_pkg::PROD_W-1]}}, prod_s1};

	always_comb begin
		rnd = acc_q + wafp_pkg::ACC_W'(2048);
		flr = rnd[wafp_pkg::ACC_W-1:wafp_pkg::FRAC_DROP];
		sum = {flr[$bits(flr)-1], flr}
			+ {{($bits(sum) - wafp_pkg::COORD_W){shift_s2[wafp_pkg::COORD_W-1]}}, shift_s2};
		if (sum > $signed({{($bits(sum) - wafp_pkg::COORD_W){1'b0}}, wafp_pkg::POS_MAX})) begin
			sat = wafp_pkg::POS_MAX;
		end else if (sum < $signed({{($bits(sum) - wafp_pkg::COORD_W){1'b1}},
				wafp_pkg::NEG_MAX})) begin
			sat = wafp_pkg::NEG_MAX;
		end else begin
			sat = sum[wafp_pkg::COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= op.valid;
			valid_s2 <= valid_s1 && last_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod_d;
		first_s1 <= op.first;
		last_s1  <= op.last;
		axis_s1  <= op.axis;
		shift_s1 <= op.shift;
		if (valid_s1) begin
			acc_q    <= first_s1 ? prod_ext : acc_q + prod_ext;
			axis_s2  <= axis_s1;
			shift_s2 <= shift_s1;
		end
		value_s3 <= sat;
		axis_s3  <= axis_s2;
	end

	assign res.valid = valid_s3;
	assign res.axis  = axis_s3;
	assign res.value = value_s3;
	assign busy      = valid_s1 || valid_s2 || valid_s3;

endmodule

/* sv/wafp_ctrl.sv */
`timescale 1ns / 1ps
module wafp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           mac_busy,
	input  logic           out_space,
	output wafp_pkg::ctl_t ctl
);

	wafp_pkg::state_t state_q, state_d;
	logic [2:0]       corner_q;
	logic [1:0]       row_q;
	logic [1:0]       term_q;
	logic             last_step;

	assign last_step = (corner_q == 3'd7) && (row_q == 2'd2) && (term_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wafp_pkg::ST_IDLE;
			corner_q <= '0;
			row_q    <= '0;
			term_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wafp_pkg::ST_RUN) begin
				// advance term, then row, then corner
				if (term_q == 2'd2) begin
					term_q <= '0;
					if (row_q == 2'd2) begin
						row_q    <= '0;
						corner_q <= corner_q + 3'd1;
					end else begin
						row_q <= row_q + 2'd1;
					end
				end else begin
					term_q <= term_q + 2'd1;
				end
			end else begin
				corner_q <= '0;
				row_q    <= '0;
				term_q   <= '0;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		ctl.idle         = 1'b0;
		ctl.done         = 1'b0;
		ctl.step.valid   = 1'b0;
		ctl.step.corner  = corner_q;
		ctl.step.row     = row_q;
		ctl.step.term    = term_q;
		unique case (state_q)
			wafp_pkg::ST_IDLE: begin
				ctl.idle = 1'b1;
				if (start) begin
					state_d = wafp_pkg::ST_RUN;
				end
			end
			wafp_pkg::ST_RUN: begin
				ctl.step.valid = 1'b1;
				if (last_step) begin
					state_d = wafp_pkg::ST_DRAIN;
				end
			end
			wafp_pkg::ST_DRAIN: begin
				if (!mac_busy && out_space) begin
					ctl.done = 1'b1;
					state_d  = wafp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wafp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/world_aabb_from_points_core.sv */
// World bounding box of a streamed mesh.
// points: one vertex per item (signed Q16.16 x, y, z plus final_point). A vertex
// without final_point is folded into the running box, and the block stays ready
// for the next vertex.
// On a vertex with final_point the eight corners of the running box are mapped
// through the 3x3 Q4.12 matrix and Q16.16 translation held in the config
// registers. One 16x32 multiplier does all 72 products, one a cycle, followed by
// an accumulate, round, translate and saturate path, so the block takes no new
// vertex until the result is loaded.
// boxes: one item per final vertex, the saturated world minimum and maximum per
// axis, held in an output register until taken. A stalled receiver only holds
// the block at the point of loading the next result; earlier vertices flow on.
// cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
// Reset (arst_n low) clears the running box to its extremes, empties the
// output register and returns the registers to the identity transform.
`timescale 1ns / 1ps
`include "world_aabb_from_points_core_macros.svh"
module world_aabb_from_points_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [47:0]          cfg_data,
	wafp_point_if.sink           points,
	wafp_box_if.source           boxes
);

	logic [wafp_pkg::ROW_W-1:0]          row_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] shift_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] low_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] high_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] wmin_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] wmax_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] pt [3];
	logic signed [wafp_pkg::COORD_W-1:0] out_min_q [3];
	logic signed [wafp_pkg::COORD_W-1:0] out_max_q [3];
	logic                                out_valid_q;

	wafp_pkg::ctl_t     ctl;
	wafp_pkg::mac_op_t  op;
	wafp_pkg::mac_res_t res;
	logic               mac_busy;
	logic               accept;
	logic               start;
	logic               out_space;
	logic               hi_sel;

	assign pt[0] = points.point_x;
	assign pt[1] = points.point_y;
	assign pt[2] = points.point_z;

	assign points.ready = ctl.idle;
	assign accept       = points.valid && ctl.idle;
	assign start        = accept && points.final_point;
	assign out_space    = !out_valid_q || boxes.ready;

	wafp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mac_busy  (mac_busy),
		.out_space (out_space),
		.ctl       (ctl)
	);

	always_comb begin
		unique case (ctl.step.term)
			2'd0:    hi_sel = ctl.step.corner[2];
			2'd1:    hi_sel = ctl.step.corner[1];
			default: hi_sel = ctl.step.corner[0];
		endcase
		op.valid = ctl.step.valid;
		op.first = ctl.step.term == 2'd0;
		op.last  = ctl.step.term == 2'd2;
		op.axis  = ctl.step.row;
		op.coef  = row_q[ctl.step.row][ctl.step.term * wafp_pkg::COEF_W +: wafp_pkg::COEF_W];
		op.coord = hi_sel ? high_q[ctl.step.term] : low_q[ctl.step.term];
		op.shift = shift_q[ctl.step.row];
	end

	wafp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= wafp_pkg::ROW_X_RESET;
			row_q[1]   <= wafp_pkg::ROW_Y_RESET;
			row_q[2]   <= wafp_pkg::ROW_Z_RESET;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wafp_pkg::REG_ROW_X:   row_q[0]   <= cfg_data;
				wafp_pkg::REG_ROW_Y:   row_q[1]   <= cfg_data;
				wafp_pkg::REG_ROW_Z:   row_q[2]   <= cfg_data;
				wafp_pkg::REG_SHIFT_X: shift_q[0] <= cfg_data[wafp_pkg::COORD_W-1:0];
				wafp_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_data[wafp_pkg::COORD_W-1:0];
				wafp_pkg::REG_SHIFT_Z: shift_q[2] <= cfg_data[wafp_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				low_q[a]  <= wafp_pkg::POS_MAX;
				high_q[a] <= wafp_pkg::NEG_MAX;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				for (int a = 0; a < 3; a++) begin
					if (pt[a] < low_q[a]) low_q[a] <= pt[a];
					if (pt[a] > high_q[a]) high_q[a] <= pt[a];
				end
			end else if (ctl.done) begin
				for (int a = 0; a < 3; a++) begin
					low_q[a]  <= wafp_pkg::POS_MAX;
					high_q[a] <= wafp_pkg::NEG_MAX;
				end
			end
			if (ctl.done) begin
				out_valid_q <= 1'b1;
			end else if (boxes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int a = 0; a < 3; a++) begin
				wmin_q[a] <= wafp_pkg::POS_MAX;
				wmax_q[a] <= wafp_pkg::NEG_MAX;
			end
		end else if (res.valid) begin
			if (res.value < wmin_q[res.axis]) wmin_q[res.axis] <= res.value;
			if (res.value > wmax_q[res.axis]) wmax_q[res.axis] <= res.value;
		end
		if (ctl.done) begin
			out_min_q <= wmin_q;
			out_max_q <= wmax_q;
		end
	end

	assign boxes.valid       = out_valid_q;
	assign boxes.world_min_x = out_min_q[0];
	assign boxes.world_min_y = out_min_q[1];
	assign boxes.world_min_z = out_min_q[2];
	assign boxes.world_max_x = out_max_q[0];
	assign boxes.world_max_y = out_max_q[1];
	assign boxes.world_max_z = out_max_q[2];

	`WAFP_CHECK_NEXT(a_box_cleared, ctl.done,
		(low_q[0] == wafp_pkg::POS_MAX) && (high_q[2] == wafp_pkg::NEG_MAX),
		"running box not cleared after result")
	`WAFP_CHECK(a_no_result_idle, res.valid, !ctl.idle, "mapped coordinate while idle")
	`WAFP_CHECK(a_box_order, boxes.valid,
		(boxes.world_min_x <= boxes.world_max_x) && (boxes.world_min_y <= boxes.world_max_y)
		&& (boxes.world_min_z <= boxes.world_max_z),
		"world box minimum above maximum")

endmodule
